// ----- rtl/calendar_date_add_days_top_defines.svh -----
// Assertion macros shared by the calendar date adder RTL.
`ifndef CALENDAR_DATE_ADD_DAYS_TOP_DEFINES_SVH
`define CALENDAR_DATE_ADD_DAYS_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define CDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define CDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cda_pkg.sv -----
package cda_pkg;

    localparam int OFFSET_BITS = 18;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INPUT = 2'd1,
        ST_RANGE     = 2'd2
    } t_cda_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_RUN
    } t_cda_state;

    typedef struct packed {
        logic [4:0]             start_day;
        logic [3:0]             start_month;
        logic [11:0]            start_year;
        logic [OFFSET_BITS-1:0] day_offset;
    } t_cda_in;

    typedef struct packed {
        logic [4:0]  result_day;
        logic [3:0]  result_month;
        logic [11:0] result_year;
        t_cda_status status;
    } t_cda_out;

    typedef struct packed {
        logic [4:0]  day;
        logic [3:0]  month;
        logic [11:0] year;
    } t_cda_date;

    localparam logic [11:0] YEAR_MIN  = 12'd1900;
    localparam logic [11:0] YEAR_MAX  = 12'd2100;
    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_DEC = 4'd12;
    localparam logic [4:0]  DAY_FIRST = 5'd1;
    localparam logic [4:0]  DAY_DEC31 = 5'd31;

    // Leap rule for years 1899..2101: the only century years there are
    // 1900, 2000 and 2100, and of those only 2000 is a multiple of 400.
    function automatic logic is_leap(input logic [11:0] year);
        return (year[1:0] == 2'b00) && (year != 12'd1900) && (year != 12'd2100);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- rtl/cda_step.sv -----
module cda_step (
    input  cda_pkg::t_cda_date i_date,
    input  logic               i_back,
    output cda_pkg::t_cda_date o_date
);
    import cda_pkg::*;

    logic       w_leap;
    logic [4:0] w_len;
    logic [3:0] w_prev_month;

    assign w_leap       = is_leap(i_date.year);
    assign w_len        = month_len(i_date.month, w_leap);
    assign w_prev_month = i_date.month - 4'd1;

    always_comb begin
        o_date = i_date;
        if (!i_back) begin
            // advance one day, carry into month and year
            if (i_date.day >= w_len) begin
                o_date.day = DAY_FIRST;
                if (i_date.month == MONTH_DEC) begin
                    o_date.month = MONTH_JAN;
                    o_date.year  = i_date.year + 12'd1;
                end else begin
                    o_date.month = i_date.month + 4'd1;
                end
            end else begin
                o_date.day = i_date.day + 5'd1;
            end
        end else begin
            // go back one day, borrow from month and year
            if (i_date.day == DAY_FIRST) begin
                if (i_date.month == MONTH_JAN) begin
                    o_date.day   = DAY_DEC31;
                    o_date.month = MONTH_DEC;
                    o_date.year  = i_date.year - 12'd1;
                end else begin
                    o_date.day   = month_len(w_prev_month, w_leap);
                    o_date.month = w_prev_month;
                end
            end else begin
                o_date.day = i_date.day - 5'd1;
            end
        end
    end

endmodule

// ----- rtl/calendar_date_add_days_top.sv -----
// Adds a signed day offset to a Gregorian date (years 1900..2100). Pulse
// start while busy is low; the date and offset are taken at that edge and
// busy rises. A check state tests the date, then a one-day step unit walks
// the calendar one day per cycle. A result appears after |day_offset| steps,
// or earlier when the walk leaves 1900..2100 (then after at most about
// 73,500 day steps), or straight after the date check for an invalid date.
// Each result is shown for exactly one cycle with o_valid high and cannot be
// stalled; the receiver must take it in that cycle. Status 1 marks an invalid
// date, 2 a result year out of range; date fields read zero on error.
`include "calendar_date_add_days_top_defines.svh"

module calendar_date_add_days_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  cda_pkg::t_cda_in  i_start_date,
    output logic              busy,
    output logic              o_valid,
    output cda_pkg::t_cda_out o_result
);
    import cda_pkg::*;

    t_cda_state             r_state, n_state;
    logic                   r_valid, n_valid;
    t_cda_out               r_out, n_out;
    t_cda_date              r_date, n_date;
    logic [OFFSET_BITS-1:0] r_count, n_count;
    logic                   r_back, n_back;

    t_cda_date              w_next;
    logic [4:0]             w_len;
    logic                   w_bad_date;
    logic                   w_year_out;

    logic                   w_err_strobe;
    logic                   w_ok_strobe;
    logic                   w_res_zero;
    logic                   w_res_in_range;

    cda_step u_step (
        .i_date (r_date),
        .i_back (r_back),
        .o_date (w_next)
    );

    assign w_len      = month_len(r_date.month, is_leap(r_date.year));
    assign w_year_out = (r_date.year < YEAR_MIN) || (r_date.year > YEAR_MAX);
    assign w_bad_date = w_year_out || (r_date.day == 5'd0) || (r_date.day > w_len)
                      || (r_date.month < MONTH_JAN) || (r_date.month > MONTH_DEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_date  <= n_date;
        r_count <= n_count;
        r_back  <= n_back;
    end

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_out   = r_out;
        n_date  = r_date;
        n_count = r_count;
        n_back  = r_back;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_date.day   = i_start_date.start_day;
                    n_date.month = i_start_date.start_month;
                    n_date.year  = i_start_date.start_year;
                    n_back       = i_start_date.day_offset[OFFSET_BITS-1];
                    // magnitude; the most negative offset maps to 2^(N-1)
                    n_count      = n_back ? (~i_start_date.day_offset + 1'b1)
                                          : i_start_date.day_offset;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (w_bad_date) begin
                    n_valid = 1'b1;
                    n_out   = '{5'd0, 4'd0, 12'd0, ST_BAD_INPUT};
                    n_state = S_IDLE;
                end else begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                // the walk is monotonic: once outside the range it stays out
                if (w_year_out) begin
                    n_valid = 1'b1;
                    n_out   = '{5'd0, 4'd0, 12'd0, ST_RANGE};
                    n_state = S_IDLE;
                end else if (r_count == '0) begin
                    n_valid = 1'b1;
                    n_out   = '{r_date.day, r_date.month, r_date.year, ST_OK};
                    n_state = S_IDLE;
                end else begin
                    n_date  = w_next;
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_out;

    assign w_err_strobe   = o_valid && (o_result.status != ST_OK);
    assign w_ok_strobe    = o_valid && (o_result.status == ST_OK);
    assign w_res_zero     = (o_result.result_day == 5'd0) && (o_result.result_month == 4'd0)
                          && (o_result.result_year == 12'd0);
    assign w_res_in_range = (o_result.result_day != 5'd0)
                          && (o_result.result_month >= MONTH_JAN)
                          && (o_result.result_month <= MONTH_DEC)
                          && (o_result.result_year >= YEAR_MIN)
                          && (o_result.result_year <= YEAR_MAX);

    `CDA_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy, "busy low after transfer")
    `CDA_ASSERT_NOW(a_err_zero, w_err_strobe, w_res_zero, "error result with nonzero date")
    `CDA_ASSERT_NOW(a_ok_in_range, w_ok_strobe, w_res_in_range, "ok result outside date range")
    `CDA_ASSERT_NEXT(a_result_frees, o_valid, !o_valid, "result strobe held past one cycle")
    `CDA_ASSERT_NOW(a_valid_idle, o_valid, !busy, "result shown while walk still running")

endmodule

// ----- bench/tb_calendar_date_add_days_top.sv -----
`timescale 1ns / 100ps

module tb_calendar_date_add_days_top;
    import cda_pkg::*;

    localparam int CYCLE_LIMIT  = 60_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int SPAN_DAYS    = 73413;   // 1900-01-01 to 2100-12-31

    typedef logic signed [OFFSET_BITS-1:0] t_offset;

    localparam t_offset OFFSET_MAX = {1'b0, {(OFFSET_BITS-1){1'b1}}};
    localparam t_offset OFFSET_MIN = {1'b1, {(OFFSET_BITS-1){1'b0}}};

    logic     i_clk        = 1'b0;
    logic     i_rst_n      = 1'b0;
    logic     start        = 1'b0;
    t_cda_in  i_start_date = '0;
    logic     busy;
    logic     o_valid;
    t_cda_out o_result;

    int unsigned idle_pct;
    int unsigned cycle_count = 0;

    class date_scoreboard;
        t_cda_out    pending_dates[$];
        int unsigned mismatches;

        function bit leap_year(longint y);
            return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
        endfunction

        function longint month_days(longint y, longint m);
            case (m)
                4, 6, 9, 11: return 30;
                2:           return leap_year(y) ? 29 : 28;
                default:     return 31;
            endcase
        endfunction

        // Day count with March as the first month of the year.
        function longint day_count(longint y, longint m, longint d);
            longint yy, era, yoe, mp, doy;
            yy  = (m <= 2) ? y - 1 : y;
            era = yy / 400;
            yoe = yy - era * 400;
            mp  = (m > 2) ? m - 3 : m + 9;
            doy = (153 * mp + 2) / 5 + d - 1;
            return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
        endfunction

        function void date_of_count(longint z, output longint y, output longint m,
                                    output longint d);
            longint era, doe, yoe, doy, mp;
            era = z / 146097;
            doe = z - era * 146097;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp  = (5 * doy + 2) / 153;
            d   = doy - (153 * mp + 2) / 5 + 1;
            m   = (mp < 10) ? mp + 3 : mp - 9;
            y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
        endfunction

        function t_cda_out shifted_date(t_cda_in d);
            t_cda_out r;
            longint   yr, mo, dy, z, delta;
            r     = '0;
            delta = t_offset'(d.day_offset);
            yr    = d.start_year;
            mo    = d.start_month;
            dy    = d.start_day;
            if (yr < YEAR_MIN || yr > YEAR_MAX || mo < 1 || mo > 12 || dy < 1 ||
                dy > month_days(yr, mo)) begin
                r.status = ST_BAD_INPUT;
                return r;
            end
            z = day_count(yr, mo, dy) + delta;
            if (z < 0) begin
                r.status = ST_RANGE;
                return r;
            end
            date_of_count(z, yr, mo, dy);
            if (yr < YEAR_MIN || yr > YEAR_MAX) begin
                r.status = ST_RANGE;
                return r;
            end
            r.result_day   = 5'(dy);
            r.result_month = 4'(mo);
            r.result_year  = 12'(yr);
            r.status       = ST_OK;
            return r;
        endfunction

        function void note_transfer(t_cda_in d);
            pending_dates.push_back(shifted_date(d));
        endfunction

        function void check_result(t_cda_out got);
            t_cda_out want;
            if (pending_dates.size() == 0) begin
                $display("%0t: result with no transfer waiting: day %0d month %0d year %0d %s",
                         $time, got.result_day, got.result_month, got.result_year,
                         got.status.name());
                mismatches++;
                return;
            end
            want = pending_dates.pop_front();
            if (got.result_day !== want.result_day) begin
                $display("%0t: result_day expected %0d actual %0d",
                         $time, want.result_day, got.result_day);
                mismatches++;
            end
            if (got.result_month !== want.result_month) begin
                $display("%0t: result_month expected %0d actual %0d",
                         $time, want.result_month, got.result_month);
                mismatches++;
            end
            if (got.result_year !== want.result_year) begin
                $display("%0t: result_year expected %0d actual %0d",
                         $time, want.result_year, got.result_year);
                mismatches++;
            end
            if (got.status !== want.status) begin
                $display("%0t: status expected %s actual %0d",
                         $time, want.status.name(), got.status);
                mismatches++;
            end
        endfunction
    endclass

    date_scoreboard sb;

    calendar_date_add_days_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_start_date(i_start_date),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_result    (o_result)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_result);
    end

    function automatic t_cda_in make_date(int dd, int mm, int yy);
        t_cda_in d;
        d.start_day   = 5'(dd);
        d.start_month = 4'(mm);
        d.start_year  = 12'(yy);
        d.day_offset  = '0;
        return d;
    endfunction

    // Enter and leave on a falling edge; start is rerolled every cycle, so
    // gaps land both while the walk runs and once busy has dropped.
    task automatic send_date(input t_cda_in d, input t_offset off);
        bit      done;
        t_cda_in cmd;
        done           = 1'b0;
        cmd            = d;
        cmd.day_offset = off;
        i_start_date <= cmd;
        while (!done) begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge i_clk);
            if (start && !busy) begin
                sb.note_transfer(cmd);
                done = 1'b1;
            end
            @(negedge i_clk);
        end
    endtask

    task automatic random_transfer();
        t_cda_in d;
        t_offset off;
        int      pick;
        int      len;
        pick = $urandom_range(99);
        if (pick < 8) begin
            d.start_day   = 5'($urandom_range(31));
            d.start_month = 4'($urandom_range(15));
            d.start_year  = 12'($urandom_range(4095));
        end else begin
            if (pick < 23) begin
                case ($urandom_range(3))
                    0:       d.start_year = YEAR_MIN;
                    1:       d.start_year = YEAR_MIN + 12'd1;
                    2:       d.start_year = YEAR_MAX - 12'd1;
                    default: d.start_year = YEAR_MAX;
                endcase
            end else begin
                d.start_year = 12'($urandom_range(YEAR_MAX, YEAR_MIN));
            end
            d.start_month = 4'($urandom_range(12, 1));
            len  = int'(sb.month_days(d.start_year, d.start_month));
            pick = $urandom_range(99);
            if (pick < 20)
                d.start_day = 5'(len);
            else if (pick < 25)
                d.start_day = 5'(len + 1);
            else if (pick < 30)
                d.start_day = DAY_FIRST;
            else
                d.start_day = 5'($urandom_range(len, 1));
        end
        // Keep most walks short; a few span the whole offset range.
        pick = $urandom_range(99);
        if (pick < 85)
            off = t_offset'(int'($urandom_range(4000)) - 2000);
        else if (pick < 95)
            off = t_offset'(int'($urandom_range(60000)) - 30000);
        else
            off = t_offset'($urandom);
        send_date(d, off);
    endtask

    initial begin
        sb = new();
        idle_pct = 35;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_date(make_date(29, 2, 2000), 0);
        send_date(make_date(1, 1, 1900), 0);
        send_date(make_date(31, 12, 2100), 0);
        send_date(make_date(29, 2, 1900), 1);
        send_date(make_date(29, 2, 2100), 5);
        send_date(make_date(30, 2, 2000), 1);
        send_date(make_date(0, 6, 2000), 1);
        send_date(make_date(31, 4, 2020), -1);
        send_date(make_date(1, 0, 2000), 1);
        send_date(make_date(1, 13, 2000), 1);
        send_date(make_date(15, 6, 1899), 1);
        send_date(make_date(15, 6, 2101), -1);
        send_date(make_date(31, 15, 4095), -1);
        send_date(make_date(0, 0, 0), OFFSET_MIN);
        send_date(make_date(31, 12, 2100), 1);
        send_date(make_date(1, 1, 1900), -1);
        send_date(make_date(31, 12, 2099), 1);
        send_date(make_date(28, 2, 2000), 1);
        send_date(make_date(28, 2, 1900), 1);
        send_date(make_date(1, 3, 2000), -1);
        send_date(make_date(1, 3, 2100), -1);
        send_date(make_date(1, 1, 1900), SPAN_DAYS);
        send_date(make_date(31, 12, 2100), -SPAN_DAYS);
        send_date(make_date(1, 1, 1900), OFFSET_MAX);
        send_date(make_date(31, 12, 2100), OFFSET_MIN);

        repeat (25) random_transfer();
        idle_pct = 83;
        repeat (25) random_transfer();
        idle_pct = 0;
        repeat (25) random_transfer();
        start <= 1'b0;

        while (sb.pending_dates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_dates.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
